@@ design/pid_pkg.sv @@
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants of the PID step core
// Widths of the datapath, reset values and indexes of the registers and the
// control word that the sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_pkg;

  localparam int PID_DATA_WIDTH = 32;

  localparam int FRAC_W    = 16;  // fraction bits of Q16.16
  localparam int ERR_W     = 33;  // target - measured
  localparam int ERRD_W    = 34;  // error - previous error
  localparam int SUM_W     = 48;  // integral
  localparam int X_W       = 50;  // widest operand of a gain product
  localparam int CHUNK_W   = 25;  // low slice of a split gain operand
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 82;
  localparam int TERM_W    = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] STEP_TIME_RST = 16'd655;
  localparam logic [15:0] STEP_RATE_RST = 16'd100;

  // Register map of the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_STEP_TIME = 3'd3,
    REG_STEP_RATE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic acc_load;  // start a term with the low partial product
    logic acc_add;   // add the high partial product, shifted up
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ design/pid_step_core.sv @@
// ----------------------------------------------------------------------------
// pid_step_core: fixed-point PID controller, one drive word per sample
// Error, saturating integral and derivative with a shared multiplier.
// ----------------------------------------------------------------------------
// A new input word is taken only in the idle state: the single shared
// multiplier serves one sample at a time, and the sequencer walks it through
// two scaling and six partial gain products.
// Reset (synchronous, rst_n low): gains cleared, step_time 655, step_rate 100,
// integral and previous error cleared, sequencer idle, result valid dropped.
`default_nettype none

module pid_step_core #(
  parameter int DATA_WIDTH = pid_pkg::PID_DATA_WIDTH
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Input words.
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [63:0]                           in_tdata,   // measured[31:0], target[63:32]
  // Result words.
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [31:0]                           out_tdata,  // drive[31:0]
  // Register writes.
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [pid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [pid_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pid_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_MUL_EDT  = 12'b0000_0000_0010,
    S_MUL_DIFF = 12'b0000_0000_0100,
    S_P_LO     = 12'b0000_0000_1000,
    S_P_HI     = 12'b0000_0001_0000,
    S_I_LO     = 12'b0000_0010_0000,
    S_I_HI     = 12'b0000_0100_0000,
    S_D_LO     = 12'b0000_1000_0000,
    S_D_HI     = 12'b0001_0000_0000,
    S_FIN_ADD  = 12'b0010_0000_0000,
    S_FIN_SUM  = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  // Saturation range of the drive in a 64-bit frame.
  localparam logic [63:0]        OUT_MASK = {64{1'b1}} >> (64 - DATA_WIDTH);
  localparam logic signed [63:0] OUT_MAX  = signed'(OUT_MASK >> 1);
  localparam logic signed [63:0] OUT_MIN  = ~OUT_MAX;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r;
  logic [15:0]        step_time_r, step_rate_r;

  // Controller state that lives across samples.
  logic signed [SUM_W-1:0] esum_r;
  logic signed [ERR_W-1:0] last_r;

  // Per-sample working registers.
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERRD_W-1:0] errd_r;
  logic signed [ERR_W-1:0]  edt_r;
  logic signed [X_W-1:0]    diff_r;
  logic signed [TERM_W-1:0] total_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic signed [ERR_W-1:0]     err_in;
  logic signed [SUM_W:0]       sum_wide;
  logic signed [SUM_W-1:0]     sum_sat;
  logic signed [X_W-1:0]       x_sel;
  logic signed [MUL_A_W-1:0]   x_lo, x_hi;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  mac_ctrl_t                   mac_ctrl;
  logic signed [PROD_W-1:0]    prod;
  logic signed [TERM_W-1:0]    term;
  logic signed [63:0]          drive_sat;
  logic [63:0]                 drive_bits;
  logic                        in_acc, out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The result register takes the new word once the previous one is gone,
  // so a slow consumer only holds the sequencer in its last step.
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign err_in = {in_tdata[63], in_tdata[63:32]} - {in_tdata[31], in_tdata[31:0]};

  // Integral update, clamped to the signed 48-bit range.
  assign sum_wide = {esum_r[SUM_W-1], esum_r}
                  + {{(SUM_W + 1 - ERR_W){edt_r[ERR_W-1]}}, edt_r};
  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = {sum_wide[SUM_W], {(SUM_W - 1){~sum_wide[SUM_W]}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // Operand of the gain products, split into an unsigned low slice and a
  // signed high slice so that each partial product fits the multiplier.
  always_comb begin
    case (state_r)
      S_P_LO, S_P_HI: x_sel = {{(X_W - ERR_W){edt_r[ERR_W-1]}}, edt_r};
      S_I_LO, S_I_HI: x_sel = {{(X_W - SUM_W){esum_r[SUM_W-1]}}, esum_r};
      default:        x_sel = diff_r;
    endcase
  end

  assign x_lo = {{(MUL_A_W - CHUNK_W){1'b0}}, x_sel[CHUNK_W-1:0]};
  assign x_hi = {{(MUL_A_W - (X_W - CHUNK_W)){x_sel[X_W-1]}}, x_sel[X_W-1:CHUNK_W]};

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mac_ctrl = '0;
    case (state_r)
      S_MUL_EDT: begin
        mul_a = {{(MUL_A_W - ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = {{(MUL_B_W - 16){1'b0}}, step_time_r};
      end
      S_MUL_DIFF: begin
        mul_a = errd_r;
        mul_b = {{(MUL_B_W - 16){1'b0}}, step_rate_r};
      end
      S_P_LO: begin
        mul_a = x_lo;
        mul_b = {gain_p_r[31], gain_p_r};
      end
      S_P_HI: begin
        mul_a = x_hi;
        mul_b = {gain_p_r[31], gain_p_r};
        mac_ctrl.acc_load = 1'b1;
      end
      S_I_LO: begin
        mul_a = x_lo;
        mul_b = {gain_i_r[31], gain_i_r};
        mac_ctrl.acc_add = 1'b1;
      end
      S_I_HI: begin
        mul_a = x_hi;
        mul_b = {gain_i_r[31], gain_i_r};
        mac_ctrl.acc_load = 1'b1;
      end
      S_D_LO: begin
        mul_a = x_lo;
        mul_b = {gain_d_r[31], gain_d_r};
        mac_ctrl.acc_add = 1'b1;
      end
      S_D_HI: begin
        mul_a = x_hi;
        mul_b = {gain_d_r[31], gain_d_r};
        mac_ctrl.acc_load = 1'b1;
      end
      S_FIN_ADD: begin
        mac_ctrl.acc_add = 1'b1;
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  pid_mac u_mac (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .ctrl (mac_ctrl),
    .prod (prod),
    .term (term)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_acc) state_nxt = S_MUL_EDT;
      S_MUL_EDT:  state_nxt = S_MUL_DIFF;
      S_MUL_DIFF: state_nxt = S_P_LO;
      S_P_LO:     state_nxt = S_P_HI;
      S_P_HI:     state_nxt = S_I_LO;
      S_I_LO:     state_nxt = S_I_HI;
      S_I_HI:     state_nxt = S_D_LO;
      S_D_LO:     state_nxt = S_D_HI;
      S_D_HI:     state_nxt = S_FIN_ADD;
      S_FIN_ADD:  state_nxt = S_FIN_SUM;
      S_FIN_SUM:  state_nxt = S_DONE;
      S_DONE:     if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and the controller memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      step_time_r <= STEP_TIME_RST;
      step_rate_r <= STEP_RATE_RST;
      esum_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:    gain_p_r    <= cfg_data[31:0];
          REG_GAIN_I:    gain_i_r    <= cfg_data[31:0];
          REG_GAIN_D:    gain_d_r    <= cfg_data[31:0];
          REG_STEP_TIME: step_time_r <= cfg_data[15:0];
          REG_STEP_RATE: step_rate_r <= cfg_data[15:0];
          default: ;  // Unknown index: the write is dropped.
        endcase
      end
      if (state_r == S_P_LO) begin
        esum_r <= sum_sat;
        last_r <= err_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current sample.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r   <= err_in;
      total_r <= '0;
    end
    if (state_r == S_MUL_EDT) begin
      errd_r <= {err_r[ERR_W-1], err_r} - {last_r[ERR_W-1], last_r};
    end
    if (state_r == S_MUL_DIFF) begin
      // err * step_time / 2^16, floored by dropping the fraction.
      edt_r <= prod[ERR_W+FRAC_W-1:FRAC_W];
    end
    if (state_r == S_P_LO) begin
      diff_r <= prod[X_W-1:0];
    end
    if (state_r == S_I_HI || state_r == S_D_HI || state_r == S_FIN_SUM) begin
      total_r <= total_r + term;
    end
    if (out_load) begin
      out_data_r <= drive_bits[31:0];
    end
  end

  always_comb begin
    if (total_r > OUT_MAX) begin
      drive_sat = OUT_MAX;
    end else if (total_r < OUT_MIN) begin
      drive_sat = OUT_MIN;
    end else begin
      drive_sat = total_r;
    end
  end

  assign drive_bits = drive_sat & OUT_MASK;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted sample always starts the sequence.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_MUL_EDT))
    else $error("accepted sample did not start the sequence");

  // A finished result waits while the previous word is still held.
  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result register overwritten before it was taken");

  // The previous error only moves in the integral update step.
  a_last_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_P_LO) |=> $stable(last_r))
    else $error("previous error changed outside its update step");

  // A new result word only appears out of the final step.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word raised outside the final step");

endmodule

`default_nettype wire

@@ design/pid_mac.sv @@
// ----------------------------------------------------------------------------
// pid_mac: shared multiplier with term accumulator
// Registered signed multiplier, an accumulator that joins the two halves of
// a split gain product, and the floor and clamp of the finished term.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_mac (
  input  wire                                  clk,
  input  wire  logic signed [pid_pkg::MUL_A_W-1:0] a,
  input  wire  logic signed [pid_pkg::MUL_B_W-1:0] b,
  input  wire  pid_pkg::mac_ctrl_t             ctrl,
  output logic signed [pid_pkg::PROD_W-1:0]    prod,
  output logic signed [pid_pkg::TERM_W-1:0]    term
);
  import pid_pkg::*;

  localparam int FLOOR_W = ACC_W - FRAC_W;
  localparam logic signed [FLOOR_W-1:0] TERM_POS = FLOOR_W'(1) << 61;
  localparam logic signed [FLOOR_W-1:0] TERM_NEG = -TERM_POS;

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   low_ext;
  logic signed [ACC_W-1:0]   high_ext;
  logic signed [FLOOR_W-1:0] floor_v;
  logic signed [FLOOR_W-1:0] clamp_v;

  assign low_ext  = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign high_ext = {prod_r[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (ctrl.acc_load) begin
      acc_r <= low_ext;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + high_ext;
    end
  end

  // Dropping the low bits of a two's complement value rounds toward minus
  // infinity, which is the floor the term needs.
  assign floor_v = acc_r[ACC_W-1:FRAC_W];

  always_comb begin
    if (floor_v > TERM_POS) begin
      clamp_v = TERM_POS;
    end else if (floor_v < TERM_NEG) begin
      clamp_v = TERM_NEG;
    end else begin
      clamp_v = floor_v;
    end
  end

  assign prod = prod_r;
  assign term = clamp_v[TERM_W-1:0];

endmodule

`default_nettype wire
